@@ design/e2q_pkg.sv @@
package e2q_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int QUAT_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STEPS       = 30;
  localparam int CW                 = 34;
  localparam int ZW                 = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic [31:0] v;
    begin
      case (i)
        0:  v = 32'h20000000;
        1:  v = 32'h12E4051E;
        2:  v = 32'h09FB385B;
        3:  v = 32'h051111D4;
        4:  v = 32'h028B0D43;
        5:  v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;
        7:  v = 32'h00517C55;
        8:  v = 32'h0028BE53;
        9:  v = 32'h00145F2F;
        10: v = 32'h000A2F98;
        11: v = 32'h000517CC;
        12: v = 32'h00028BE6;
        13: v = 32'h000145F3;
        14: v = 32'h0000A2FA;
        15: v = 32'h0000517D;
        16: v = 32'h000028BE;
        17: v = 32'h0000145F;
        18: v = 32'h00000A30;
        19: v = 32'h00000518;
        20: v = 32'h0000028C;
        21: v = 32'h00000146;
        22: v = 32'h000000A3;
        23: v = 32'h00000051;
        24: v = 32'h00000029;
        25: v = 32'h00000014;
        26: v = 32'h0000000A;
        27: v = 32'h00000005;
        28: v = 32'h00000003;
        29: v = 32'h00000001;
        default: v = 32'h0;
      endcase
      atan_step = $signed({1'b0, v});
    end
  endfunction

endpackage

@@ design/euler_to_quaternion.sv @@
// ZYX Euler angles to quaternion, fully pipelined: one word in and one out every
// cycle while the output is not stalled (1 load stage, 30 CORDIC stages per angle,
// 4 stages of products, sums and saturation). The whole pipe advances only when the
// output register is empty or being taken, so stalls lose nothing.
module euler_to_quaternion #(
  parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS_DEF,
  parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // roll_angle, pitch_angle, yaw_angle
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*(QUAT_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);
  import e2q_pkg::*;

  localparam int OW  = 4*(QUAT_FRAC_BITS+1);
  localparam int OBW = ((OW+7)/8)*8;

  logic en, cv, qv;
  logic signed [CW-1:0] cs [6];
  logic [OW-1:0] quat;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = qv;

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk, .rst, .en,
    .in_valid(s_tvalid),
    .angles(s_tdata[3*ANGLE_BITS-1:0]),
    .out_valid(cv),
    .cs
  );

  e2q_combine #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_combine (
    .clk, .rst, .en,
    .in_valid(cv),
    .cs,
    .out_valid(qv),
    .quat
  );

  assign m_tdata = OBW'(quat);
endmodule

@@ design/e2q_cordic.sv @@
module e2q_cordic #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [3*ANGLE_BITS-1:0]       angles,
  output logic                          out_valid,
  output logic signed [e2q_pkg::CW-1:0] cs [6]
);
  import e2q_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                  vld [N+1];
  logic signed [CW-1:0]  xs  [N+1][3];
  logic signed [CW-1:0]  ys  [N+1][3];
  logic signed [ZW-1:0]  zs  [N+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_load
    logic [31:0] a32;
    assign a32 = 32'({angles[a*ANGLE_BITS +: ANGLE_BITS], (32-ANGLE_BITS+1)'(0)} >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        xs[0][a] <= CORDIC_GAIN;
        ys[0][a] <= '0;
        zs[0][a] <= $signed({{(ZW-31){a32[31]}}, a32[31:1]});
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    for (genvar a = 0; a < 3; a++) begin : g_ax
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zs[i][a][ZW-1]) begin
            xs[i+1][a] <= xs[i][a] - (ys[i][a] >>> i);
            ys[i+1][a] <= ys[i][a] + (xs[i][a] >>> i);
            zs[i+1][a] <= zs[i][a] - atan_step(i);
          end else begin
            xs[i+1][a] <= xs[i][a] + (ys[i][a] >>> i);
            ys[i+1][a] <= ys[i][a] - (xs[i][a] >>> i);
            zs[i+1][a] <= zs[i][a] + atan_step(i);
          end
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign cs[0] = xs[N][0];
  assign cs[1] = ys[N][0];
  assign cs[2] = xs[N][1];
  assign cs[3] = ys[N][1];
  assign cs[4] = xs[N][2];
  assign cs[5] = ys[N][2];
endmodule

@@ design/e2q_combine.sv @@
module e2q_combine #(
  parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [e2q_pkg::CW-1:0] cs [6],
  output logic                          out_valid,
  output logic [4*(QUAT_FRAC_BITS+1)-1:0] quat
);
  import e2q_pkg::*;

  localparam int PW = 2*CW;
  localparam int TW = 64;
  localparam int QW = QUAT_FRAC_BITS + 1;
  localparam int SH = 60 - QUAT_FRAC_BITS;

  logic [3:0] vld;
  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;
  assign cr = cs[0];
  assign sr = cs[1];
  assign cp = cs[2];
  assign sp = cs[3];
  assign cy = cs[4];
  assign sy = cs[5];

  logic signed [PW-1:0] p [8];
  logic signed [CW-1:0] pr [8];
  logic signed [CW-1:0] c3 [8];
  logic signed [CW-1:0] c3r [8];
  logic signed [TW-1:0] t [8];
  logic signed [TW:0]   sum [4];

  always_comb begin
    p[0] = cr * cp; c3[0] = cy;
    p[1] = sr * sp; c3[1] = sy;
    p[2] = sr * cp; c3[2] = cy;
    p[3] = cr * sp; c3[3] = sy;
    p[4] = cr * sp; c3[4] = cy;
    p[5] = sr * cp; c3[5] = sy;
    p[6] = cr * cp; c3[6] = sy;
    p[7] = sr * sp; c3[7] = cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_tri
    logic signed [PW-1:0] pq;
    logic signed [CW-1:0] pn;
    assign pq = p[k] + (PW'(1) <<< 29);
    assign pn = CW'(pq >>> 30);
    always_ff @(posedge clk) begin
      if (en) begin
        pr[k]  <= pn;
        c3r[k] <= c3[k];
        t[k]   <= TW'(pr[k] * c3r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum[0] <= {t[0][TW-1], t[0]} + {t[1][TW-1], t[1]};
      sum[1] <= {t[2][TW-1], t[2]} - {t[3][TW-1], t[3]};
      sum[2] <= {t[4][TW-1], t[4]} + {t[5][TW-1], t[5]};
      sum[3] <= {t[6][TW-1], t[6]} - {t[7][TW-1], t[7]};
    end
  end

  for (genvar q = 0; q < 4; q++) begin : g_out
    logic signed [TW:0] r;
    logic signed [TW:0] rs;
    assign r  = sum[q] + ((TW+1)'(1) <<< (SH-1));
    assign rs = r >>> SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rs > (TW+1)'((1 << QUAT_FRAC_BITS) - 1)) begin
          quat[q*QW +: QW] <= {1'b0, {QUAT_FRAC_BITS{1'b1}}};
        end else if (rs < -((TW+1)'(1) <<< QUAT_FRAC_BITS)) begin
          quat[q*QW +: QW] <= {1'b1, {QUAT_FRAC_BITS{1'b0}}};
        end else begin
          quat[q*QW +: QW] <= rs[QW-1:0];
        end
      end
    end
  end

  assign out_valid = vld[3];
endmodule

@@ design/e2q_checker.sv @@
module e2q_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input blocked while output empty");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("output valid after reset");
endmodule

bind euler_to_quaternion e2q_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready
);

@@ tb/tb_euler_to_quaternion.sv @@
module tb_euler_to_quaternion;
  import e2q_pkg::*;

  localparam int AB = 16;
  localparam int QF = 15;
  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] w;
  } quat_t;

  typedef struct {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    bit          known;
    quat_t       q;
  } angle_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata;
  logic [63:0] m_tdata;

  euler_to_quaternion dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  quat_t quat_queue[$];
  int errors = 0;
  int cycles = 0;
  int words_out = 0;
  angle_row_t rows[$];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void half_cos_sin(logic [15:0] code, output longint c,
                                       output longint s);
    longint z, x, y, dx, dy, ang;
    logic signed [31:0] full;
    full = {code, 16'h0};
    z = shr_floor(longint'(full), 1);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      ang = longint'(atan_step(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= ang;
      end else begin
        x += dx; y -= dy; z += ang;
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return shr_floor(a * b + (64'sd1 <<< 29), 30) * c;
  endfunction

  function automatic logic [15:0] sat_q15(longint v);
    longint r;
    r = shr_floor(v + (64'sd1 <<< (59 - QF)), 60 - QF);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t angles_to_quat(logic [15:0] r, logic [15:0] p,
                                           logic [15:0] yw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_cos_sin(r, cr, sr);
    half_cos_sin(p, cp, sp);
    half_cos_sin(yw, cy, sy);
    q.w = sat_q15(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = sat_q15(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = sat_q15(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = sat_q15(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_angles(logic [15:0] r, logic [15:0] p, logic [15:0] yw);
    s_tvalid <= 1'b1;
    s_tdata <= {yw, p, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    quat_queue.push_back(angles_to_quat(r, p, yw));
  endtask

  task automatic add_row(logic [15:0] r, logic [15:0] p, logic [15:0] yw,
                         bit known, quat_t q);
    angle_row_t a;
    a.roll = r; a.pitch = p; a.yaw = yw; a.known = known; a.q = q;
    rows.push_back(a);
  endtask

  // receive side: random stalls, compare each word to the oldest prediction
  initial begin
    quat_t got, want;
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        words_out++;
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = quat_queue.pop_front();
          if (got.w !== want.w) begin
            $display("%0t: w expected %h actual %h", $time, want.w, got.w); errors++;
          end
          if (got.x !== want.x) begin
            $display("%0t: x expected %h actual %h", $time, want.x, got.x); errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: y expected %h actual %h", $time, want.y, got.y); errors++;
          end
          if (got.z !== want.z) begin
            $display("%0t: z expected %h actual %h", $time, want.z, got.z); errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 149) == 0) begin
        hold = $urandom_range(10, 60);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    quat_t q0;
    quat_t id;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    id = '{w: 16'h7fff, x: 16'h0000, y: 16'h0000, z: 16'h0000};
    q0 = '0;
    // zero angles give the identity quaternion
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, id);
    add_row(16'h8000, 16'h0000, 16'h0000, 1'b0, q0);
    add_row(16'h0000, 16'h8000, 16'h0000, 1'b0, q0);
    add_row(16'h0000, 16'h0000, 16'h8000, 1'b0, q0);
    add_row(16'h8000, 16'h8000, 16'h8000, 1'b0, q0);
    add_row(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, q0);
    add_row(16'hffff, 16'h0001, 16'hffff, 1'b0, q0);
    add_row(16'h4000, 16'h0000, 16'h0000, 1'b0, q0);
    add_row(16'h0000, 16'h4000, 16'h0000, 1'b0, q0);
    add_row(16'h0000, 16'h0000, 16'h4000, 1'b0, q0);
    add_row(16'hc000, 16'hc000, 16'hc000, 1'b0, q0);
    add_row(16'h2000, 16'he000, 16'h6000, 1'b0, q0);
    add_row(16'h5555, 16'haaaa, 16'h5555, 1'b0, q0);
    add_row(16'haaaa, 16'h5555, 16'haaaa, 1'b0, q0);

    foreach (rows[i]) begin
      if (rows[i].known && angles_to_quat(rows[i].roll, rows[i].pitch, rows[i].yaw)
          !== rows[i].q) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i, rows[i].q,
                 angles_to_quat(rows[i].roll, rows[i].pitch, rows[i].yaw));
        errors++;
      end
      send_angles(rows[i].roll, rows[i].pitch, rows[i].yaw);
    end

    s_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      logic [15:0] r, p, yw;
      r = $urandom; p = $urandom; yw = $urandom;
      if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
      if ($urandom_range(0, 9) == 0) yw = $urandom_range(0, 1) ? 16'hffff : 16'h4000;
      stall = (n > 100 && n < 400) ? 0 : gap_len();
      if (stall > 0) begin
        s_tvalid <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (n == 700) begin
        s_tvalid <= 1'b0;
        while (quat_queue.size() != 0) @(posedge clk);
      end
      send_angles(r, p, yw);
    end
    s_tvalid <= 1'b0;

    while (quat_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d words: zero, half-turn and wrap angles plus random attitudes,",
             words_out);
    $display("with random gaps and backpressure on both streams");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
